/* rtl/core/rmls_pkg.sv */
`default_nettype none

package rmls_pkg;

  // elapsed tick counter width default
  localparam int TICK_COUNT_BITS_DEFAULT = 16;

  // configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_W      = 10;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TX_START_LIMIT       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TX_DONE_LIMIT        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_HOLD_TICKS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY_TICKS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE_SETTLE_TICKS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SEND_LENGTH      = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] TX_START_LIMIT_RST       = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] TX_DONE_LIMIT_RST        = 16'd3000;
  localparam logic [CFG_DATA_W-1:0] RESET_HOLD_TICKS_RST     = 16'd10;
  localparam logic [CFG_DATA_W-1:0] RESET_RECOVERY_TICKS_RST = 16'd1000;
  localparam logic [CFG_DATA_W-1:0] MODE_SETTLE_TICKS_RST    = 16'd600;
  localparam logic [LEN_W-1:0]      MAX_SEND_LENGTH_RST      = 10'd512;

  // input opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_SEND   = 2'd1;
  localparam logic [1:0] OP_CONFIG = 2'd2;

  // reply codes
  localparam logic [1:0] RPL_NONE    = 2'd0;
  localparam logic [1:0] RPL_ACCEPT  = 2'd1;
  localparam logic [1:0] RPL_BUSY    = 2'd2;
  localparam logic [1:0] RPL_BAD_LEN = 2'd3;

  // event codes
  localparam logic [1:0] EVT_NONE    = 2'd0;
  localparam logic [1:0] EVT_DONE    = 2'd1;
  localparam logic [1:0] EVT_TIMEOUT = 2'd2;

  // state classes
  localparam logic [1:0] CLS_IDLE     = 2'd0;
  localparam logic [1:0] CLS_TRANSMIT = 2'd1;
  localparam logic [1:0] CLS_CONFIG   = 2'd2;
  localparam logic [1:0] CLS_RESET    = 2'd3;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] tx_start_limit;
    logic [CFG_DATA_W-1:0] tx_done_limit;
    logic [CFG_DATA_W-1:0] reset_hold_ticks;
    logic [CFG_DATA_W-1:0] reset_recovery_ticks;
    logic [CFG_DATA_W-1:0] mode_settle_ticks;
    logic [LEN_W-1:0]      max_send_length;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/rmls_in_if.sv */
`default_nettype none

interface rmls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       busy_level;
  logic [rmls_pkg::LEN_W-1:0] send_length;

  modport source (output valid, output opcode, output busy_level, output send_length,
                  input ready);
  modport sink (input valid, input opcode, input busy_level, input send_length,
                output ready);
endinterface

`default_nettype wire

/* rtl/core/rmls_out_if.sv */
`default_nettype none

interface rmls_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] reply;
  logic [1:0] event_res;
  logic       mode_pin;
  logic       reset_pin;
  logic       write_pulse;
  logic [1:0] state_class;
  logic       stuck_flag;

  modport source (output valid, output reply, output event_res, output mode_pin,
                  output reset_pin, output write_pulse, output state_class,
                  output stuck_flag, input ready);
  modport sink (input valid, input reply, input event_res, input mode_pin,
                input reset_pin, input write_pulse, input state_class,
                input stuck_flag, output ready);
endinterface

`default_nettype wire

/* rtl/core/rmls_cfg_regs.sv */
`default_nettype none

module rmls_cfg_regs (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [rmls_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rmls_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rmls_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tx_start_limit       <= rmls_pkg::TX_START_LIMIT_RST;
      cfg.tx_done_limit        <= rmls_pkg::TX_DONE_LIMIT_RST;
      cfg.reset_hold_ticks     <= rmls_pkg::RESET_HOLD_TICKS_RST;
      cfg.reset_recovery_ticks <= rmls_pkg::RESET_RECOVERY_TICKS_RST;
      cfg.mode_settle_ticks    <= rmls_pkg::MODE_SETTLE_TICKS_RST;
      cfg.max_send_length      <= rmls_pkg::MAX_SEND_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rmls_pkg::REG_TX_START_LIMIT:       cfg.tx_start_limit       <= cfg_data;
        rmls_pkg::REG_TX_DONE_LIMIT:        cfg.tx_done_limit        <= cfg_data;
        rmls_pkg::REG_RESET_HOLD_TICKS:     cfg.reset_hold_ticks     <= cfg_data;
        rmls_pkg::REG_RESET_RECOVERY_TICKS: cfg.reset_recovery_ticks <= cfg_data;
        rmls_pkg::REG_MODE_SETTLE_TICKS:    cfg.mode_settle_ticks    <= cfg_data;
        rmls_pkg::REG_MAX_SEND_LENGTH:
          cfg.max_send_length <= cfg_data[rmls_pkg::LEN_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/radio_module_link_sequencer_unit.sv */
// Link sequencer for a radio module with busy, mode and active-low reset pins. Each input
// beat is a one-millisecond tick, a send request or a config request together with the
// sampled busy level, and each input beat yields exactly one result beat in the next cycle.
// The block takes a new beat every clock as long as the result register is empty or being
// drained in the same cycle: the phase, elapsed counter and pin levels are updated by one
// shallow level of logic (a saturating increment, a compare against a limit register and
// the phase decode) at the accepting edge, so throughput is one beat per cycle. After reset
// the sequencer starts with a reset pulse on the module (hold, release, recovery) and
// answers requests with rejected-busy until that ends. The user must write configuration
// registers through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
`default_nettype none

module radio_module_link_sequencer_unit #(
  parameter int TICK_COUNT_BITS = rmls_pkg::TICK_COUNT_BITS_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  rmls_in_if.sink                              in_ch,
  rmls_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [rmls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rmls_pkg::CFG_DATA_W-1:0] cfg_data
);

  // compare width covers both the counter and the 16-bit limits
  localparam int CmpW = (TICK_COUNT_BITS > rmls_pkg::CFG_DATA_W) ?
                        TICK_COUNT_BITS : rmls_pkg::CFG_DATA_W;

  typedef enum logic [3:0] {
    PH_IDLE        = 4'd0,
    PH_TX_RISE     = 4'd1,
    PH_TX_FALL     = 4'd2,
    PH_CFG_ENTER   = 4'd3,
    PH_CFG_STABLE  = 4'd4,
    PH_CFG_EXIT    = 4'd5,
    PH_CFG_RECOVER = 4'd6,
    PH_RST_HOLD    = 4'd7,
    PH_RST_RELEASE = 4'd8,
    PH_RST_READY   = 4'd9
  } phase_t;

  rmls_pkg::cfg_t cfg;

  // sequencer state
  phase_t                     phase, phase_next;
  logic [TICK_COUNT_BITS-1:0] ticks, ticks_next, elapsed;
  logic                       mode_level, mode_level_next;
  logic                       reset_level, reset_level_next;

  // result of the beat being accepted
  logic [1:0] reply_next, event_next, class_next;
  logic       write_next, stuck_next;

  // result register
  logic       out_valid;
  logic [1:0] reply, event_res, state_class;
  logic       mode_pin, reset_pin, write_pulse, stuck_flag;

  logic in_fire;

  rmls_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // accept whenever the result register is free or emptying this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  function automatic logic [1:0] class_of(phase_t p);
    logic [1:0] c;
    if (p == PH_IDLE) begin
      c = rmls_pkg::CLS_IDLE;
    end else if (p >= PH_RST_HOLD) begin
      c = rmls_pkg::CLS_RESET;
    end else if (p >= PH_CFG_ENTER) begin
      c = rmls_pkg::CLS_CONFIG;
    end else begin
      c = rmls_pkg::CLS_TRANSMIT;
    end
    return c;
  endfunction

  function automatic logic over_limit(logic [TICK_COUNT_BITS-1:0] el,
                                      logic [rmls_pkg::CFG_DATA_W-1:0] lim);
    return CmpW'(el) > CmpW'(lim);
  endfunction

  // saturating elapsed count for this tick
  assign elapsed = (ticks == {TICK_COUNT_BITS{1'b1}}) ? ticks
                                                      : ticks + TICK_COUNT_BITS'(1);

  always_comb begin
    phase_next       = phase;
    ticks_next       = ticks;
    mode_level_next  = mode_level;
    reset_level_next = reset_level;
    reply_next       = rmls_pkg::RPL_NONE;
    event_next       = rmls_pkg::EVT_NONE;
    write_next       = 1'b0;
    stuck_next       = 1'b0;

    if (in_ch.opcode == rmls_pkg::OP_SEND || in_ch.opcode == rmls_pkg::OP_CONFIG) begin
      // requests do not advance time
      if (phase != PH_IDLE) begin
        reply_next = rmls_pkg::RPL_BUSY;
      end else if (in_ch.opcode == rmls_pkg::OP_SEND &&
                   (in_ch.send_length == '0 ||
                    in_ch.send_length > cfg.max_send_length)) begin
        reply_next = rmls_pkg::RPL_BAD_LEN;
      end else begin
        reply_next = rmls_pkg::RPL_ACCEPT;
        ticks_next = '0;
        if (in_ch.opcode == rmls_pkg::OP_SEND) begin
          write_next = 1'b1;
          phase_next = PH_TX_RISE;
        end else begin
          phase_next = PH_CFG_ENTER;
        end
      end
    end else if (in_ch.opcode == rmls_pkg::OP_TICK && phase != PH_IDLE) begin
      ticks_next = elapsed;
      unique case (phase)
        PH_TX_RISE: begin
          // wait for busy to rise
          if (in_ch.busy_level) begin
            phase_next = PH_TX_FALL;
            ticks_next = '0;
          end else if (over_limit(elapsed, cfg.tx_start_limit)) begin
            event_next = rmls_pkg::EVT_TIMEOUT;
            phase_next = PH_RST_HOLD;
            ticks_next = '0;
          end
        end
        PH_TX_FALL: begin
          // wait for busy to fall
          if (!in_ch.busy_level) begin
            event_next = rmls_pkg::EVT_DONE;
            phase_next = PH_IDLE;
            ticks_next = '0;
          end else if (over_limit(elapsed, cfg.tx_done_limit)) begin
            event_next = rmls_pkg::EVT_TIMEOUT;
            phase_next = PH_RST_HOLD;
            ticks_next = '0;
          end
        end
        PH_CFG_ENTER: begin
          mode_level_next = 1'b1;
          phase_next      = PH_CFG_STABLE;
          ticks_next      = '0;
        end
        PH_CFG_STABLE: begin
          if (over_limit(elapsed, cfg.mode_settle_ticks)) begin
            phase_next = PH_CFG_EXIT;
            ticks_next = '0;
          end
        end
        PH_CFG_EXIT: begin
          mode_level_next = 1'b0;
          phase_next      = PH_CFG_RECOVER;
          ticks_next      = '0;
        end
        PH_CFG_RECOVER: begin
          if (over_limit(elapsed, cfg.mode_settle_ticks) && !in_ch.busy_level) begin
            event_next = rmls_pkg::EVT_DONE;
            phase_next = PH_IDLE;
            ticks_next = '0;
          end
        end
        PH_RST_HOLD: begin
          // reset pin driven low for the hold time
          reset_level_next = 1'b0;
          if (over_limit(elapsed, cfg.reset_hold_ticks)) begin
            phase_next = PH_RST_RELEASE;
            ticks_next = '0;
          end
        end
        PH_RST_RELEASE: begin
          reset_level_next = 1'b1;
          phase_next       = PH_RST_READY;
          ticks_next       = '0;
        end
        PH_RST_READY: begin
          // after recovery, wait for idle; flag a module that stays busy
          if (over_limit(elapsed, cfg.reset_recovery_ticks)) begin
            if (!in_ch.busy_level) begin
              phase_next = PH_IDLE;
              ticks_next = '0;
            end else begin
              stuck_next = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
          ticks_next = '0;
        end
      endcase
    end

    class_next = class_of(phase_next);
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_RST_HOLD;
      ticks       <= '0;
      mode_level  <= 1'b0;
      reset_level <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (in_fire) begin
        phase       <= phase_next;
        ticks       <= ticks_next;
        mode_level  <= mode_level_next;
        reset_level <= reset_level_next;
        out_valid   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      reply       <= reply_next;
      event_res   <= event_next;
      mode_pin    <= mode_level_next;
      reset_pin   <= reset_level_next;
      write_pulse <= write_next;
      state_class <= class_next;
      stuck_flag  <= stuck_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.reply       = reply;
  assign out_ch.event_res   = event_res;
  assign out_ch.mode_pin    = mode_pin;
  assign out_ch.reset_pin   = reset_pin;
  assign out_ch.write_pulse = write_pulse;
  assign out_ch.state_class = state_class;
  assign out_ch.stuck_flag  = stuck_flag;

  // reset pin is only driven low in the hold phase and until the release tick
  a_reset_low_in_hold: assert property (@(posedge clk) disable iff (rst)
    !reset_level |-> (phase == PH_RST_HOLD || phase == PH_RST_RELEASE))
    else $error("reset pin low outside reset hold");

  // mode pin is only high while settling in config mode and until the exit tick
  a_mode_high_in_stable: assert property (@(posedge clk) disable iff (rst)
    mode_level |-> (phase == PH_CFG_STABLE || phase == PH_CFG_EXIT))
    else $error("mode pin high outside config settle");

  // every accepted beat yields a result beat on the next cycle
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("accepted beat produced no result");

  // a write pulse comes only with an accepted send
  a_write_with_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_pulse |->
      reply == rmls_pkg::RPL_ACCEPT && state_class == rmls_pkg::CLS_TRANSMIT)
    else $error("write pulse without accepted send");

  // a transmit timeout always leads into the reset sequence, pin drops on the first hold tick
  a_timeout_to_reset: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == rmls_pkg::EVT_TIMEOUT |->
      state_class == rmls_pkg::CLS_RESET && reset_pin)
    else $error("timeout did not start reset sequence");

endmodule

`default_nettype wire
